FILE: hdl/segic_pkg.sv
// Package for the segment intersection classifier.
// Holds the beat types, the status flag bundle, class codes and register indexes.
// No dependencies.
package segic_pkg;

    localparam int FIELD_W = 16;

    localparam logic [2:0] CODE_NONE    = 3'd0;
    localparam logic [2:0] CODE_PROPER  = 3'd1;
    localparam logic [2:0] CODE_VERTEX  = 3'd2;
    localparam logic [2:0] CODE_OVERLAP = 3'd3;
    localparam logic [2:0] CODE_SAME    = 3'd4;

    localparam logic [1:0] CFG_EPS_COORD = 2'd0;
    localparam logic [1:0] CFG_EPS_AREA  = 2'd1;
    localparam logic [1:0] CFG_IGNORE    = 2'd2;

    typedef struct packed {
        logic signed [FIELD_W-1:0] ax;
        logic signed [FIELD_W-1:0] ay;
        logic signed [FIELD_W-1:0] bx;
        logic signed [FIELD_W-1:0] by_coord;
        logic signed [FIELD_W-1:0] cx;
        logic signed [FIELD_W-1:0] cy;
        logic signed [FIELD_W-1:0] dx;
        logic signed [FIELD_W-1:0] dy;
    } in_t;

    typedef struct packed {
        logic [2:0]                code;
        logic                      hit;
        logic                      point_valid;
        logic signed [FIELD_W-1:0] point_x;
        logic signed [FIELD_W-1:0] point_y;
    } out_t;

    typedef struct packed {
        logic [2:0]                code;
        logic                      point_valid;
        logic signed [FIELD_W-1:0] point_x;
        logic signed [FIELD_W-1:0] point_y;
    } tag_t;

    typedef struct packed {
        logic same;
        logic vtx_a;
        logic vtx_b;
        logic ins_c;
        logic ins_d;
        logic ins_a;
        logic ins_b;
    } flags_t;

endpackage

FILE: hdl/segic_geom.sv
// Five-stage front end: endpoint tests, cross products, determinant and
// numerators for the crossing point, and classification. Uses segic_pkg.
module segic_geom #(
    parameter int COORD_WIDTH = 16,
    localparam int CW = (COORD_WIDTH < segic_pkg::FIELD_W) ? COORD_WIDTH : segic_pkg::FIELD_W,
    localparam int SW = 2 * CW + 3,
    localparam int NW = 3 * CW + 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  segic_pkg::in_t        in_item,
    input  logic [14:0]           eps_coord,
    input  logic [31:0]           eps_area,
    output logic                  out_valid,
    output logic signed [NW-1:0]  num_x,
    output logic signed [NW-1:0]  num_y,
    output logic signed [SW-1:0]  den,
    output segic_pkg::tag_t       tag
);
    import segic_pkg::*;

    localparam int DFW = CW + 1;
    localparam int PW  = 2 * CW + 2;
    localparam int MW  = NW - 1;

    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by_coord;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
    } pts_t;

    function automatic logic near(input logic signed [CW-1:0] u,
                                  input logic signed [CW-1:0] v,
                                  input logic [14:0] eps);
        logic signed [CW:0] d;
        logic [CW:0]        mag;
        d   = DFW'(u) - DFW'(v);
        mag = d[CW] ? -d : d;
        return 33'(mag) <= 33'(eps);
    endfunction

    function automatic logic between(input logic signed [CW-1:0] p,
                                     input logic signed [CW-1:0] q,
                                     input logic signed [CW-1:0] r);
        return (p <= r && r <= q) || (p >= r && r >= q);
    endfunction

    function automatic logic in_unit(input logic signed [SW-1:0] n,
                                     input logic signed [SW-1:0] d);
        if (d > 0)
            return n >= 0 && n <= d;
        return n <= 0 && n >= d;
    endfunction

    function automatic logic near_area(input logic signed [SW-1:0] n,
                                       input logic [31:0] eps);
        logic [SW-1:0] mag;
        mag = n[SW-1] ? -n : n;
        return 64'(mag) <= 64'(eps);
    endfunction

    // Stage 1: endpoint proximity, betweenness and edge differences.
    pts_t   pts_next;
    flags_t flg_next;
    logic   n_acx, n_acy, n_bdx, n_bdy, n_adx, n_ady, n_bcx, n_bcy, n_abx, n_cdx;

    always_comb
    begin
        pts_next.ax       = $signed(in_item.ax[CW-1:0]);
        pts_next.ay       = $signed(in_item.ay[CW-1:0]);
        pts_next.bx       = $signed(in_item.bx[CW-1:0]);
        pts_next.by_coord = $signed(in_item.by_coord[CW-1:0]);
        pts_next.cx       = $signed(in_item.cx[CW-1:0]);
        pts_next.cy       = $signed(in_item.cy[CW-1:0]);
        pts_next.dx       = $signed(in_item.dx[CW-1:0]);
        pts_next.dy       = $signed(in_item.dy[CW-1:0]);
        n_acx = near(pts_next.ax, pts_next.cx, eps_coord);
        n_acy = near(pts_next.ay, pts_next.cy, eps_coord);
        n_bdx = near(pts_next.bx, pts_next.dx, eps_coord);
        n_bdy = near(pts_next.by_coord, pts_next.dy, eps_coord);
        n_adx = near(pts_next.ax, pts_next.dx, eps_coord);
        n_ady = near(pts_next.ay, pts_next.dy, eps_coord);
        n_bcx = near(pts_next.bx, pts_next.cx, eps_coord);
        n_bcy = near(pts_next.by_coord, pts_next.cy, eps_coord);
        n_abx = near(pts_next.ax, pts_next.bx, eps_coord);
        n_cdx = near(pts_next.cx, pts_next.dx, eps_coord);
        flg_next.same  = (n_acx && n_acy && n_bdx && n_bdy) ||
                         (n_adx && n_ady && n_bcx && n_bcy);
        flg_next.vtx_a = (n_acx && n_acy) || (n_adx && n_ady);
        flg_next.vtx_b = (n_bdx && n_bdy) || (n_bcx && n_bcy);
        flg_next.ins_c = n_abx ? between(pts_next.ay, pts_next.by_coord, pts_next.cy)
                               : between(pts_next.ax, pts_next.bx, pts_next.cx);
        flg_next.ins_d = n_abx ? between(pts_next.ay, pts_next.by_coord, pts_next.dy)
                               : between(pts_next.ax, pts_next.bx, pts_next.dx);
        flg_next.ins_a = n_cdx ? between(pts_next.cy, pts_next.dy, pts_next.ay)
                               : between(pts_next.cx, pts_next.dx, pts_next.ax);
        flg_next.ins_b = n_cdx ? between(pts_next.cy, pts_next.dy, pts_next.by_coord)
                               : between(pts_next.cx, pts_next.dx, pts_next.bx);
    end

    logic                  v1_reg;
    pts_t                  pts1_reg;
    flags_t                flg1_reg;
    logic signed [DFW-1:0] e1x_reg, e1y_reg, e2x_reg, e2y_reg, wx_reg, wy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        pts1_reg <= pts_next;
        flg1_reg <= flg_next;
        e1x_reg  <= DFW'(pts_next.bx) - DFW'(pts_next.ax);
        e1y_reg  <= DFW'(pts_next.by_coord) - DFW'(pts_next.ay);
        e2x_reg  <= DFW'(pts_next.dx) - DFW'(pts_next.cx);
        e2y_reg  <= DFW'(pts_next.dy) - DFW'(pts_next.cy);
        wx_reg   <= DFW'(pts_next.cx) - DFW'(pts_next.ax);
        wy_reg   <= DFW'(pts_next.cy) - DFW'(pts_next.ay);
    end

    // Stage 2: the six cross-product terms.
    logic                  v2_reg;
    pts_t                  pts2_reg;
    flags_t                flg2_reg;
    logic signed [DFW-1:0] e1x2_reg, e1y2_reg;
    logic signed [PW-1:0]  p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        pts2_reg <= pts1_reg;
        flg2_reg <= flg1_reg;
        e1x2_reg <= e1x_reg;
        e1y2_reg <= e1y_reg;
        p1_reg   <= PW'(e2x_reg) * PW'(e1y_reg);
        p2_reg   <= PW'(e1x_reg) * PW'(e2y_reg);
        p3_reg   <= PW'(wy_reg) * PW'(e2x_reg);
        p4_reg   <= PW'(wx_reg) * PW'(e2y_reg);
        p5_reg   <= PW'(e1x_reg) * PW'(wy_reg);
        p6_reg   <= PW'(e1y_reg) * PW'(wx_reg);
    end

    // Stage 3: determinant and the two parameter numerators.
    logic                  v3_reg;
    pts_t                  pts3_reg;
    flags_t                flg3_reg;
    logic signed [DFW-1:0] e1x3_reg, e1y3_reg;
    logic signed [SW-1:0]  den3_reg, ns3_reg, nt3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        pts3_reg <= pts2_reg;
        flg3_reg <= flg2_reg;
        e1x3_reg <= e1x2_reg;
        e1y3_reg <= e1y2_reg;
        den3_reg <= SW'(p1_reg) - SW'(p2_reg);
        ns3_reg  <= SW'(p3_reg) - SW'(p4_reg);
        nt3_reg  <= SW'(p5_reg) - SW'(p6_reg);
    end

    // Stage 4: tolerance and range tests, numerator products of the point.
    logic                 v4_reg;
    pts_t                 pts4_reg;
    flags_t               flg4_reg;
    logic signed [SW-1:0] den4_reg;
    logic signed [MW-1:0] m1_reg, m2_reg, m3_reg, m4_reg;
    logic                 par_reg, col_reg, us_reg, ut_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        pts4_reg <= pts3_reg;
        flg4_reg <= flg3_reg;
        den4_reg <= den3_reg;
        m1_reg   <= MW'(pts3_reg.ax) * MW'(den3_reg);
        m2_reg   <= MW'(ns3_reg) * MW'(e1x3_reg);
        m3_reg   <= MW'(pts3_reg.ay) * MW'(den3_reg);
        m4_reg   <= MW'(ns3_reg) * MW'(e1y3_reg);
        par_reg  <= near_area(den3_reg, eps_area);
        col_reg  <= near_area(nt3_reg, eps_area);
        us_reg   <= in_unit(ns3_reg, den3_reg);
        ut_reg   <= in_unit(nt3_reg, den3_reg);
    end

    // Stage 5: classification and the point numerators.
    tag_t tag_next;

    always_comb
    begin
        tag_next.code        = CODE_NONE;
        tag_next.point_valid = 1'b0;
        tag_next.point_x     = '0;
        tag_next.point_y     = '0;
        priority if (flg4_reg.same)
        begin
            tag_next.code = CODE_SAME;
        end
        else if (flg4_reg.vtx_a)
        begin
            tag_next.code    = CODE_VERTEX;
            tag_next.point_x = FIELD_W'(pts4_reg.ax);
            tag_next.point_y = FIELD_W'(pts4_reg.ay);
        end
        else if (flg4_reg.vtx_b)
        begin
            tag_next.code    = CODE_VERTEX;
            tag_next.point_x = FIELD_W'(pts4_reg.bx);
            tag_next.point_y = FIELD_W'(pts4_reg.by_coord);
        end
        else if (par_reg)
        begin
            if (col_reg)
            begin
                priority if (flg4_reg.ins_c)
                begin
                    tag_next.code    = CODE_OVERLAP;
                    tag_next.point_x = FIELD_W'(pts4_reg.cx);
                    tag_next.point_y = FIELD_W'(pts4_reg.cy);
                end
                else if (flg4_reg.ins_d)
                begin
                    tag_next.code    = CODE_OVERLAP;
                    tag_next.point_x = FIELD_W'(pts4_reg.dx);
                    tag_next.point_y = FIELD_W'(pts4_reg.dy);
                end
                else if (flg4_reg.ins_a)
                begin
                    tag_next.code    = CODE_OVERLAP;
                    tag_next.point_x = FIELD_W'(pts4_reg.ax);
                    tag_next.point_y = FIELD_W'(pts4_reg.ay);
                end
                else if (flg4_reg.ins_b)
                begin
                    tag_next.code    = CODE_OVERLAP;
                    tag_next.point_x = FIELD_W'(pts4_reg.bx);
                    tag_next.point_y = FIELD_W'(pts4_reg.by_coord);
                end
                else
                begin
                    tag_next.code = CODE_NONE;
                end
            end
        end
        else if (us_reg && ut_reg)
        begin
            tag_next.code = CODE_PROPER;
        end
        else
        begin
            tag_next.code = CODE_NONE;
        end
        tag_next.point_valid = (tag_next.code == CODE_PROPER) ||
                               (tag_next.code == CODE_VERTEX) ||
                               (tag_next.code == CODE_OVERLAP);
    end

    logic                 v5_reg;
    logic signed [NW-1:0] num_x_reg, num_y_reg;
    logic signed [SW-1:0] den5_reg;
    tag_t                 tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else
            v5_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        num_x_reg <= NW'(m1_reg) + NW'(m2_reg);
        num_y_reg <= NW'(m3_reg) + NW'(m4_reg);
        den5_reg  <= den4_reg;
        tag_reg   <= tag_next;
    end

    assign out_valid = v5_reg;
    assign num_x     = num_x_reg;
    assign num_y     = num_y_reg;
    assign den       = den5_reg;
    assign tag       = tag_reg;

endmodule

FILE: hdl/segic_div.sv
// Pipelined restoring divider, one quotient bit per stage, for both point
// coordinates at once; truncates toward zero. Uses segic_pkg.
module segic_div #(
    parameter int COORD_WIDTH = 16,
    localparam int CW = (COORD_WIDTH < segic_pkg::FIELD_W) ? COORD_WIDTH : segic_pkg::FIELD_W,
    localparam int SW = 2 * CW + 3,
    localparam int NW = 3 * CW + 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic signed [NW-1:0]  num_x,
    input  logic signed [NW-1:0]  num_y,
    input  logic signed [SW-1:0]  den,
    input  segic_pkg::tag_t       in_tag,
    output logic                  out_valid,
    output logic signed [CW-1:0]  quot_x,
    output logic signed [CW-1:0]  quot_y,
    output segic_pkg::tag_t       out_tag
);
    import segic_pkg::*;

    localparam int QB = CW;

    logic          v_reg   [0:QB];
    logic [NW-1:0] rx_reg  [0:QB];
    logic [NW-1:0] ry_reg  [0:QB];
    logic [QB-1:0] qx_reg  [0:QB];
    logic [QB-1:0] qy_reg  [0:QB];
    logic [SW-1:0] dm_reg  [0:QB];
    logic          negx_reg[0:QB];
    logic          negy_reg[0:QB];
    tag_t          tag_reg [0:QB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        rx_reg[0]   <= num_x[NW-1] ? NW'(-num_x) : NW'(num_x);
        ry_reg[0]   <= num_y[NW-1] ? NW'(-num_y) : NW'(num_y);
        dm_reg[0]   <= den[SW-1] ? SW'(-den) : SW'(den);
        qx_reg[0]   <= '0;
        qy_reg[0]   <= '0;
        negx_reg[0] <= num_x[NW-1] ^ den[SW-1];
        negy_reg[0] <= num_y[NW-1] ^ den[SW-1];
        tag_reg[0]  <= in_tag;
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_stage
        logic [NW-1:0] dsh;
        logic          gex, gey;
        logic [QB-1:0] qx_next, qy_next;

        always_comb
        begin
            dsh     = NW'(dm_reg[k]) << (QB - 1 - k);
            gex     = rx_reg[k] >= dsh;
            gey     = ry_reg[k] >= dsh;
            qx_next = qx_reg[k];
            qy_next = qy_reg[k];
            qx_next[QB-1-k] = gex;
            qy_next[QB-1-k] = gey;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k+1] <= 1'b0;
            else
                v_reg[k+1] <= v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            rx_reg[k+1]   <= gex ? rx_reg[k] - dsh : rx_reg[k];
            ry_reg[k+1]   <= gey ? ry_reg[k] - dsh : ry_reg[k];
            qx_reg[k+1]   <= qx_next;
            qy_reg[k+1]   <= qy_next;
            dm_reg[k+1]   <= dm_reg[k];
            negx_reg[k+1] <= negx_reg[k];
            negy_reg[k+1] <= negy_reg[k];
            tag_reg[k+1]  <= tag_reg[k];
        end
    end

    assign out_valid = v_reg[QB];
    assign quot_x    = negx_reg[QB] ? $signed(-qx_reg[QB]) : $signed(qx_reg[QB]);
    assign quot_y    = negy_reg[QB] ? $signed(-qy_reg[QB]) : $signed(qy_reg[QB]);
    assign out_tag   = tag_reg[QB];

endmodule

FILE: hdl/segment_intersection_classify.sv
// Top level of the segment intersection classifier: configuration registers,
// the geometry front end, the divider and the result register. Uses segic_pkg.
//
// One segment pair is taken on every clock cycle; busy never rises. Each pair
// gives exactly one result beat, marked by result_valid for a single cycle,
// after passing through the geometry front end, the one-bit-per-stage divider
// that finds the crossing point and the result register. The receiver must take
// every result beat as it comes.
module segment_intersection_classify #(
    parameter int COORD_WIDTH = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  segic_pkg::in_t  item,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_index,
    input  logic [31:0]     cfg_data,
    output logic            result_valid,
    output segic_pkg::out_t result
);
    import segic_pkg::*;

    localparam int CW = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
    localparam int SW = 2 * CW + 3;
    localparam int NW = 3 * CW + 5;

    logic [14:0] eps_coord_reg;
    logic [31:0] eps_area_reg;
    logic        ignore_endpoints_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_coord_reg        <= '0;
            eps_area_reg         <= '0;
            ignore_endpoints_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_EPS_COORD: eps_coord_reg        <= cfg_data[14:0];
                CFG_EPS_AREA:  eps_area_reg         <= cfg_data;
                CFG_IGNORE:    ignore_endpoints_reg <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    logic                 geom_valid;
    logic signed [NW-1:0] num_x, num_y;
    logic signed [SW-1:0] den;
    tag_t                 geom_tag;

    segic_geom #(.COORD_WIDTH(COORD_WIDTH)) u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .in_item   (item),
        .eps_coord (eps_coord_reg),
        .eps_area  (eps_area_reg),
        .out_valid (geom_valid),
        .num_x     (num_x),
        .num_y     (num_y),
        .den       (den),
        .tag       (geom_tag)
    );

    logic                 div_valid;
    logic signed [CW-1:0] quot_x, quot_y;
    tag_t                 div_tag;

    segic_div #(.COORD_WIDTH(COORD_WIDTH)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (geom_valid),
        .num_x     (num_x),
        .num_y     (num_y),
        .den       (den),
        .in_tag    (geom_tag),
        .out_valid (div_valid),
        .quot_x    (quot_x),
        .quot_y    (quot_y),
        .out_tag   (div_tag)
    );

    out_t result_next;
    logic result_valid_reg;
    out_t result_reg;

    always_comb
    begin
        result_next.code        = div_tag.code;
        result_next.point_valid = div_tag.point_valid;
        result_next.hit         = (div_tag.code == CODE_PROPER) ||
                                  (div_tag.code == CODE_OVERLAP) ||
                                  (((div_tag.code == CODE_VERTEX) ||
                                    (div_tag.code == CODE_SAME)) && !ignore_endpoints_reg);
        if (div_tag.code == CODE_PROPER)
        begin
            result_next.point_x = FIELD_W'(quot_x);
            result_next.point_y = FIELD_W'(quot_y);
        end
        else
        begin
            result_next.point_x = div_tag.point_x;
            result_next.point_y = div_tag.point_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for segment_intersection_classify: random and directed
// segment pairs, class and crossing point predicted in the bench. Uses segic_pkg.
module testbench;
    import segic_pkg::*;

    localparam int LATENCY = 40;
    localparam int WATCHDOG = 20000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    in_t         item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        result_valid;
    out_t        result;

    in_t         pending_pairs[$];
    out_t        expected_results[$];
    logic [14:0] tol_coord;
    logic [31:0] tol_area;
    logic        skip_endpoints;
    int          idle_pct;
    int          fail_count;
    int          quiet_cycles;
    logic        cfg_done;
    logic        busy_s;
    logic        accepted;

    segment_intersection_classify u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .result_valid(result_valid), .result(result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic near_c(longint u, longint v);
        longint d;
        d = u - v;
        if (d < 0) d = -d;
        return d <= longint'(tol_coord);
    endfunction

    function automatic logic near_a(longint u, longint v);
        longint d;
        d = u - v;
        if (d < 0) d = -d;
        return d <= longint'(tol_area);
    endfunction

    function automatic logic between(longint px, longint py, longint qx, longint qy,
                                     longint rx, longint ry);
        if (!near_c(px, qx))
            return (px <= rx && rx <= qx) || (px >= rx && rx >= qx);
        return (py <= ry && ry <= qy) || (py >= ry && ry >= qy);
    endfunction

    function automatic logic unit_range(longint num, longint den);
        if (den > 0)
            return num >= 0 && num <= den;
        return num <= 0 && num >= den;
    endfunction

    function automatic out_t classify(in_t p);
        longint ax, ay, bx, by, cx, cy, dx, dy, den, ns, nt, px, py;
        logic [2:0] code;
        logic pv;
        out_t r;
        ax = p.ax; ay = p.ay; bx = p.bx; by = p.by_coord;
        cx = p.cx; cy = p.cy; dx = p.dx; dy = p.dy;
        code = CODE_NONE; pv = 1'b0; px = 0; py = 0;
        if ((near_c(ax, cx) && near_c(ay, cy) && near_c(bx, dx) && near_c(by, dy)) ||
            (near_c(ax, dx) && near_c(ay, dy) && near_c(bx, cx) && near_c(by, cy)))
            code = CODE_SAME;
        else if ((near_c(ax, cx) && near_c(ay, cy)) || (near_c(ax, dx) && near_c(ay, dy)))
        begin
            code = CODE_VERTEX; pv = 1'b1; px = ax; py = ay;
        end
        else if ((near_c(bx, dx) && near_c(by, dy)) || (near_c(bx, cx) && near_c(by, cy)))
        begin
            code = CODE_VERTEX; pv = 1'b1; px = bx; py = by;
        end
        else
        begin
            den = ax * (dy - cy) + bx * (cy - dy) + dx * (by - ay) + cx * (ay - by);
            if (near_a(den, 0))
            begin
                if (near_a((bx - ax) * (cy - ay), (cx - ax) * (by - ay)))
                begin
                    if (between(ax, ay, bx, by, cx, cy))
                    begin
                        code = CODE_OVERLAP; px = cx; py = cy;
                    end
                    else if (between(ax, ay, bx, by, dx, dy))
                    begin
                        code = CODE_OVERLAP; px = dx; py = dy;
                    end
                    else if (between(cx, cy, dx, dy, ax, ay))
                    begin
                        code = CODE_OVERLAP; px = ax; py = ay;
                    end
                    else if (between(cx, cy, dx, dy, bx, by))
                    begin
                        code = CODE_OVERLAP; px = bx; py = by;
                    end
                    pv = (code == CODE_OVERLAP);
                end
            end
            else
            begin
                ns = ax * (dy - cy) + cx * (ay - dy) + dx * (cy - ay);
                nt = -(ax * (cy - by) + bx * (ay - cy) + cx * (by - ay));
                if (unit_range(ns, den) && unit_range(nt, den))
                begin
                    code = CODE_PROPER; pv = 1'b1;
                    px = (ax * den + ns * (bx - ax)) / den;
                    py = (ay * den + ns * (by - ay)) / den;
                end
            end
        end
        r.code = code;
        r.hit = (code == CODE_PROPER || code == CODE_OVERLAP ||
                 ((code == CODE_VERTEX || code == CODE_SAME) && !skip_endpoints));
        r.point_valid = pv;
        r.point_x = px[15:0];
        r.point_y = py[15:0];
        return r;
    endfunction

    function automatic logic [15:0] rnd_coord();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 64)) - 16'd32;
            2: return ($urandom_range(0, 1) ? 16'h7fff : 16'h8000) - 16'($urandom_range(0, 2));
            default: return 16'($urandom_range(0, 2048)) - 16'd1024;
        endcase
    endfunction

    function automatic in_t random_pair();
        in_t p;
        int t;
        int k;
        int m;
        p.ax = rnd_coord(); p.ay = rnd_coord(); p.bx = rnd_coord(); p.by_coord = rnd_coord();
        p.cx = rnd_coord(); p.cy = rnd_coord(); p.dx = rnd_coord(); p.dy = rnd_coord();
        t = $urandom_range(0, 5);
        if (t == 0)
        begin
            p.cx = p.ax + 16'($urandom_range(0, 2)); p.cy = p.ay;
        end
        else if (t == 1)
        begin
            p.cx = p.bx; p.cy = p.by_coord; p.dx = p.ax; p.dy = p.ay;
        end
        else if (t == 2 || t == 3)
        begin
            // Points along one line through A with direction (k, m).
            k = $urandom_range(0, 8) - 4; m = $urandom_range(0, 8) - 4;
            p.ax = 16'($urandom_range(0, 4000)) - 16'd2000;
            p.ay = 16'($urandom_range(0, 4000)) - 16'd2000;
            p.bx = p.ax + 16'(k * 100); p.by_coord = p.ay + 16'(m * 100);
            t = $urandom_range(0, 200) - 50;
            p.cx = p.ax + 16'(k * t); p.cy = p.ay + 16'(m * t);
            t = $urandom_range(0, 200) - 50;
            p.dx = p.ax + 16'(k * t); p.dy = p.ay + 16'(m * t);
        end
        return p;
    endfunction

    function automatic in_t make_pair(int ax, int ay, int bx, int by, int cx, int cy,
                                      int dx, int dy);
        in_t p;
        p.ax = 16'(ax); p.ay = 16'(ay); p.bx = 16'(bx); p.by_coord = 16'(by);
        p.cx = 16'(cx); p.cy = 16'(cy); p.dx = 16'(dx); p.dy = 16'(dy);
        return p;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == CFG_EPS_COORD) tol_coord = val[14:0];
        else if (idx == CFG_EPS_AREA) tol_area = val;
        else if (idx == CFG_IGNORE) skip_endpoints = val[0];
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain();
        while (pending_pairs.size() != 0 || expected_results.size() != 0) @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic run_phase(int pct, int n);
        idle_pct = pct;
        repeat (n) pending_pairs.push_back(random_pair());
        drain();
    endtask

    // Driver: one pair per accepted beat, inputs move on the falling edge.
    always @(negedge clk)
    begin
        if (rst_n && start && !busy_s)
            void'(pending_pairs.pop_front());
        if (rst_n && pending_pairs.size() != 0 && $urandom_range(1, 100) > idle_pct)
        begin
            start <= 1'b1;
            item <= pending_pairs[0];
        end
        else
            start <= 1'b0;
    end

    // Monitor: predicts at acceptance, checks each result beat.
    always @(posedge clk)
    begin
        busy_s <= busy;
        accepted = rst_n && start && !busy;
        if (accepted)
            expected_results.push_back(classify(item));
        if (rst_n && result_valid)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, actual %p", $time, result);
                fail_count++;
            end
            else
            begin
                if (result !== expected_results[0])
                begin
                    $display("%0t: mismatch expected %p actual %p", $time,
                             expected_results[0], result);
                    fail_count++;
                end
                void'(expected_results.pop_front());
            end
        end
        if (accepted || result_valid || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0; start = 1'b0; item = '0; cfg_valid = 1'b0; cfg_index = CFG_EPS_COORD;
        cfg_data = '0; tol_coord = '0; tol_area = '0; skip_endpoints = 1'b0;
        idle_pct = 0; fail_count = 0; quiet_cycles = 0; busy_s = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        pending_pairs.push_back(make_pair(0, 0, 256, 256, 0, 256, 256, 0));
        pending_pairs.push_back(make_pair(0, 0, 256, 0, 0, 0, 256, 0));
        pending_pairs.push_back(make_pair(0, 0, 256, 0, 256, 0, 0, 0));
        pending_pairs.push_back(make_pair(0, 0, 256, 0, 0, 0, 0, 256));
        pending_pairs.push_back(make_pair(0, 0, 256, 0, 512, 512, 256, 0));
        pending_pairs.push_back(make_pair(0, 0, 512, 0, 256, 0, 768, 0));
        pending_pairs.push_back(make_pair(256, 0, 768, 0, 0, 0, 1024, 0));
        pending_pairs.push_back(make_pair(0, 0, 0, 512, 0, 256, 0, 768));
        pending_pairs.push_back(make_pair(0, 0, 256, 0, 0, 256, 256, 256));
        pending_pairs.push_back(make_pair(0, 0, 256, 0, 512, 0, 768, 0));
        pending_pairs.push_back(make_pair(0, 0, 256, 256, 512, 0, 768, -256));
        pending_pairs.push_back(make_pair(-32768, -32768, 32767, 32767, -32768, 32767,
                                          32767, -32768));
        pending_pairs.push_back(make_pair(32767, 32767, -32768, -32768, 32767, -32768,
                                          -32768, 32767));
        pending_pairs.push_back(make_pair(-1, 3, 5, -7, 2, -9, -3, 4));
        pending_pairs.push_back(make_pair(0, 0, 768, 0, 256, -1, 256, 1));
        pending_pairs.push_back(make_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
        drain();
        run_phase(0, 300);
        write_reg(CFG_IGNORE, 32'd1);
        write_reg(CFG_EPS_COORD, 32'd2);
        write_reg(CFG_EPS_AREA, 32'd1000);
        pending_pairs.push_back(make_pair(0, 0, 256, 0, 1, 1, 0, 256));
        pending_pairs.push_back(make_pair(0, 0, 256, 1, 0, 2, 256, 3));
        run_phase(51, 400);
        write_reg(CFG_EPS_COORD, 32'd32767);
        write_reg(CFG_EPS_AREA, 32'hffffffff);
        write_reg(CFG_IGNORE, 32'd0);
        run_phase(16, 250);
        write_reg(CFG_EPS_COORD, 32'd0);
        write_reg(CFG_EPS_AREA, 32'd0);
        run_phase(51, 500);
        write_reg(CFG_EPS_COORD, 32'd16384);
        write_reg(CFG_EPS_AREA, 32'h55555555);
        write_reg(CFG_IGNORE, 32'd1);
        run_phase(0, 200);
        write_reg(CFG_EPS_COORD, 32'd4);
        write_reg(CFG_EPS_AREA, 32'haaaa);
        run_phase(16, 280);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
